// File: hw/rtl/umd_pkg.sv
// umd_pkg: shared types and constants for the unsigned multiply/divide unit
// no dependencies; imported by umd_ctrl, umd_datapath, unsigned_mul_div_unit and the test bench

package umd_pkg;

  localparam int DATA_WIDTH_DEF = 64;
  localparam int OPCODE_W       = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_REM = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // sequencer controls for the datapath
  typedef struct packed {
    logic load;
    logic step;
  } ctl_t;

endpackage

// File: hw/rtl/umd_ctrl.sv
// umd_ctrl: sequencer that runs one bit step of the shared adder per cycle
// depends on umd_pkg

module umd_ctrl #(
  parameter int DATA_WIDTH = umd_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          slot_free,
  output logic          in_ready,
  output logic          capture,
  output umd_pkg::ctl_t ctl
);
  import umd_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
        end
      end
      ST_RUN: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    capture  = 1'b0;
    ctl      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      ST_RUN: begin
        ctl.step = 1'b1;
      end
      ST_DONE: begin
        capture = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |=> (state_r == ST_RUN) && (cnt_r == '0))
    else $error("load did not start a run at bit zero");

  a_cnt_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && (cnt_r != CNT_LAST) |=>
      (state_r == ST_RUN) && (cnt_r == $past(cnt_r) + 1'b1))
    else $error("bit counter skipped or run ended early");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && (cnt_r == CNT_LAST) |=> (state_r == ST_DONE))
    else $error("run did not finish after the last bit");

  a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
    capture |=> (state_r == ST_IDLE))
    else $error("sequencer not idle after result capture");
`endif

endmodule

// File: hw/rtl/umd_datapath.sv
// umd_datapath: operand, accumulator and quotient registers around one shared adder
// depends on umd_pkg

module umd_datapath #(
  parameter int DATA_WIDTH = umd_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  umd_pkg::ctl_t                 ctl,
  input  logic [umd_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [DATA_WIDTH-1:0]         in_operand_a,
  input  logic [DATA_WIDTH-1:0]         in_operand_b,
  output logic [DATA_WIDTH-1:0]         result
);
  import umd_pkg::*;

  op_t                  op_r;
  logic [DATA_WIDTH-1:0] a_r, a_nxt;     // multiplicand or dividend bits
  logic [DATA_WIDTH-1:0] b_r, b_nxt;     // multiplier or divisor
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt; // product or partial remainder
  logic [DATA_WIDTH-1:0] q_r, q_nxt;
  logic                  started_r, started_nxt;

  logic [DATA_WIDTH-1:0] add_x, add_y;
  logic                  add_cin;
  logic [DATA_WIDTH:0]   add_sum;

  logic                  in_bit, carry, started, take;
  logic [DATA_WIDTH-1:0] shifted;

  // shared adder: add for multiply, subtract for divide
  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DATA_WIDTH{1'b0}}, add_cin};

  assign in_bit  = a_r[DATA_WIDTH-1];
  assign carry   = acc_r[DATA_WIDTH-1];
  assign shifted = {acc_r[DATA_WIDTH-2:0], in_bit};
  assign started = started_r | in_bit;
  // carry out of shifted - b means shifted >= b
  assign take    = carry | add_sum[DATA_WIDTH];

  always_comb begin
    add_x       = acc_r;
    add_y       = b_r[0] ? a_r : '0;
    add_cin     = 1'b0;
    a_nxt       = a_r;
    b_nxt       = b_r;
    acc_nxt     = acc_r;
    q_nxt       = q_r;
    started_nxt = started_r;
    if (op_r == OP_MUL) begin
      a_nxt   = a_r << 1;
      b_nxt   = b_r >> 1;
      acc_nxt = add_sum[DATA_WIDTH-1:0];
    end else begin
      add_x       = shifted;
      add_y       = ~b_r;
      add_cin     = 1'b1;
      a_nxt       = a_r << 1;
      acc_nxt     = take ? add_sum[DATA_WIDTH-1:0] : shifted;
      // leading zeros of the dividend give no quotient bits
      q_nxt       = {q_r[DATA_WIDTH-2:0], take & started};
      started_nxt = started;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r      <= op_t'(in_opcode);
      a_r       <= in_operand_a;
      b_r       <= in_operand_b;
      acc_r     <= '0;
      q_r       <= '0;
      started_r <= 1'b0;
    end else if (ctl.step) begin
      a_r       <= a_nxt;
      b_r       <= b_nxt;
      acc_r     <= acc_nxt;
      q_r       <= q_nxt;
      started_r <= started_nxt;
    end
  end

  always_comb begin
    case (op_r)
      OP_MUL:  result = acc_r;
      OP_DIV:  result = q_r;
      OP_REM:  result = acc_r;
      default: result = '0;
    endcase
  end

endmodule

// File: hw/rtl/unsigned_mul_div_unit.sv
// unsigned_mul_div_unit: top level, sequencer + datapath + output register
// depends on umd_pkg, umd_ctrl, umd_datapath
//
//   channel  ports                                      direction
//   in       in_valid/in_ready, in_opcode,              into block
//            in_operand_a, in_operand_b
//   out      out_valid/out_ready, out_result_value      out of block
//
// after acceptance the sequencer steps through ST_RUN, one operand bit per cycle
// through the shared adder, then in ST_DONE writes the output register and sets out_valid
// a new transaction is taken only once the previous result has left ST_DONE;
// in_ready is low while a transaction is in the adder loop
// a result waiting in the output register does not block acceptance; a
// finished result waits in the sequencer only if that register is still full
// reset clears the sequencer and out_valid

module unsigned_mul_div_unit #(
  parameter int DATA_WIDTH = umd_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [umd_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [DATA_WIDTH-1:0]         in_operand_a,
  input  logic [DATA_WIDTH-1:0]         in_operand_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [DATA_WIDTH-1:0]         out_result_value
);
  import umd_pkg::*;

  ctl_t                  ctl;
  logic                  capture;
  logic                  slot_free;
  logic [DATA_WIDTH-1:0] result;

  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_result_r;

  assign slot_free = !out_valid_r || out_ready;

  umd_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .slot_free (slot_free),
    .in_ready  (in_ready),
    .capture   (capture),
    .ctl       (ctl)
  );

  umd_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .ctl          (ctl),
    .in_opcode    (in_opcode),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .result       (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      out_result_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_r;

endmodule

// File: bench/unsigned_mul_div_unit_test.sv
`timescale 1ns / 1ps
// unsigned_mul_div_unit_test: self-checking bench for the unsigned multiply/divide unit
// depends on umd_pkg and unsigned_mul_div_unit; results are predicted in a small scoreboard

typedef logic [umd_pkg::DATA_WIDTH_DEF-1:0] umd_word_t;

class umd_result_board;
  typedef struct {
    logic [umd_pkg::OPCODE_W-1:0] op;
    umd_word_t                    a;
    umd_word_t                    b;
    umd_word_t                    value;
  } umd_pending_t;

  umd_pending_t expected_results[$];
  int           mismatches;

  function new();
    mismatches = 0;
  endfunction

  // bit-serial restoring division over the significant bits of the dividend,
  // with a one-bit-wider shifted partial remainder
  static function umd_word_t restoring_quotient(umd_word_t a, umd_word_t b);
    umd_word_t                       q;
    umd_word_t                       rem;
    logic [umd_pkg::DATA_WIDTH_DEF:0] shifted;
    int                              top;
    q   = '0;
    rem = '0;
    top = 0;
    for (int i = 0; i < umd_pkg::DATA_WIDTH_DEF; i++)
      if (a[i]) top = i + 1;
    for (int i = top - 1; i >= 0; i--) begin
      shifted = {rem, a[i]};
      q = q << 1;
      if (shifted >= {1'b0, b}) begin
        rem  = shifted[umd_pkg::DATA_WIDTH_DEF-1:0] - b;
        q[0] = 1'b1;
      end else begin
        rem = shifted[umd_pkg::DATA_WIDTH_DEF-1:0];
      end
    end
    return q;
  endfunction

  static function umd_word_t predict_result(logic [umd_pkg::OPCODE_W-1:0] op,
                                            umd_word_t a, umd_word_t b);
    umd_word_t q;
    umd_word_t prod;
    q = restoring_quotient(a, b);
    case (op)
      umd_pkg::OP_MUL: begin
        prod = a * b;
        return prod;
      end
      umd_pkg::OP_DIV: return q;
      umd_pkg::OP_REM: begin
        prod = b * q;
        return a - prod;
      end
      default: return '0;
    endcase
  endfunction

  function void note_operation(logic [umd_pkg::OPCODE_W-1:0] op, umd_word_t a, umd_word_t b);
    umd_pending_t e;
    e.op    = op;
    e.a     = a;
    e.b     = b;
    e.value = predict_result(op, a, b);
    expected_results.push_back(e);
  endfunction

  function void check_result(umd_word_t got);
    umd_pending_t e;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result %h with no transaction outstanding", got);
      return;
    end
    e = expected_results.pop_front();
    if (got !== e.value) begin
      mismatches++;
      if (mismatches <= 10)
        $display("op %0d a=%h b=%h: expected %h, got %h", e.op, e.a, e.b, e.value, got);
    end
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module unsigned_mul_div_unit_test;
  import umd_pkg::*;

  localparam int                  IDLE_PCT     = 31;
  localparam int                  RANDOM_ITEMS = 780;
  localparam int                  HOLD_CYCLES  = 400;
  localparam int                  STALL_LIMIT  = 4000;
  localparam logic [OPCODE_W-1:0] OP_UNUSED    = 2'd3;
  localparam umd_word_t           ALL_ONES     = '1;
  localparam umd_word_t           TOP_BIT      = {1'b1, {(DATA_WIDTH_DEF-1){1'b0}}};

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [OPCODE_W-1:0] in_opcode    = OP_MUL;
  umd_word_t           in_operand_a = '0;
  umd_word_t           in_operand_b = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  umd_word_t           out_result_value;

  logic steady     = 1'b0;
  logic hold_start = 1'b0;
  int   hold_left  = 0;
  int   quiet_cycles = 0;

  umd_result_board book = new();

  unsigned_mul_div_unit #(.DATA_WIDTH(DATA_WIDTH_DEF)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.check_result(out_result_value);
  end

  // result side: random back-pressure or, in steady mode, always ready, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_start) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(input logic [OPCODE_W-1:0] op, input umd_word_t a,
                           input umd_word_t b);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_operation(op, a, b);
  endtask

  function automatic umd_word_t rand_operand();
    umd_word_t v;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0: v = umd_word_t'($urandom_range(15));
      1: v = umd_word_t'(1) << $urandom_range(DATA_WIDTH_DEF - 1);
      2: v = ~umd_word_t'($urandom_range(15));
      3: v = v >> $urandom_range(DATA_WIDTH_DEF - 1);
      default: ;
    endcase
    return v;
  endfunction

  initial begin : stimulus
    logic [OPCODE_W-1:0] op;
    umd_word_t           a;
    umd_word_t           b;
    int                  r;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_MUL, '0, '0);
    send_item(OP_MUL, ALL_ONES, ALL_ONES);
    send_item(OP_MUL, TOP_BIT, 64'd2);
    send_item(OP_MUL, ALL_ONES, 64'd1);
    send_item(OP_MUL, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    send_item(OP_DIV, ALL_ONES, 64'd1);
    send_item(OP_DIV, ALL_ONES, ALL_ONES);
    send_item(OP_DIV, '0, 64'd5);
    // divide by zero: quotient is ones over the dividend's bit length
    send_item(OP_DIV, 64'd5, '0);
    send_item(OP_DIV, '0, '0);
    send_item(OP_DIV, ALL_ONES, '0);
    send_item(OP_DIV, 64'd1, ALL_ONES);
    send_item(OP_DIV, TOP_BIT, 64'd3);
    send_item(OP_DIV, 64'd100, 64'd7);
    send_item(OP_DIV, ALL_ONES, TOP_BIT | 64'd1);
    send_item(OP_REM, 64'd100, 64'd7);
    send_item(OP_REM, ALL_ONES, '0);
    send_item(OP_REM, 64'd5, '0);
    send_item(OP_REM, ALL_ONES, TOP_BIT | 64'd1);
    send_item(OP_REM, ALL_ONES, 64'd3);
    send_item(OP_REM, 64'd7, 64'd7);
    send_item(OP_REM, '0, '0);
    send_item(OP_UNUSED, ALL_ONES, ALL_ONES);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 200) steady <= 1'b1;
      if (n == 330) steady <= 1'b0;
      if (n == 450) begin
        // stall the result side while the input keeps offering transactions
        in_valid   <= 1'b0;
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
      end
      if (n == 600) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0) @(posedge clk);
      end
      r = $urandom_range(99);
      if (r < 4) op = OP_UNUSED;
      else if (r < 36) op = OP_MUL;
      else if (r < 68) op = OP_DIV;
      else op = OP_REM;
      a = rand_operand();
      b = ($urandom_range(24) == 0) ? '0 : rand_operand();
      send_item(op, a, b);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
    repeat (DATA_WIDTH_DEF + 8) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
